// ===== rtl/core/mtf_pkg.sv =====
`default_nettype none

package mtf_pkg;

  localparam int ENTRIES    = 128;
  localparam int KEY_BITS   = 64;
  localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);

  // port widths fixed by the item format
  localparam int IN_KEY_W  = 64;
  localparam int OUTCOME_W = 3;
  localparam int FIELD_W   = 7;

  localparam logic [OUTCOME_W-1:0] OUT_APPENDED = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MOVED    = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_AT_FRONT = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_MISS     = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd4;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [KEY_BITS-1:0]   key_t;

  typedef struct packed {
    logic                 load;      // capture accepted item
    logic                 do_append; // write key and tail link
    logic                 start;     // read head entry
    logic                 step;      // follow link to next entry
    logic                 relink;    // bypass the hit entry
    logic                 front;     // link hit entry to old head
    logic                 set_res;   // record result
    logic [OUTCOME_W-1:0] res_code;
    logic                 out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic op;
    logic count_zero;
    logic full;
    logic key_match;
    logic pos_zero;
    logic last;
  } status_t;

  // low seven bits of a slot-wide value, zero extended when narrower
  function automatic logic [FIELD_W-1:0] to_field(input slot_t s);
    logic [SLOT_BITS+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, s};
    return wide[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtf_if.sv =====
`default_nettype none

interface mtf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [mtf_pkg::IN_KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface mtf_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtf_pkg::OUTCOME_W-1:0] outcome;
  logic [mtf_pkg::FIELD_W-1:0]   slot;
  logic [mtf_pkg::FIELD_W-1:0]   position;

  modport source (output valid, output outcome, output slot, output position, input ready);
  modport sink   (input valid, input outcome, input slot, input position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/move_to_front_list_search.sv =====
// channel   dir   handshake      payload
// in_ch     in    valid/ready    operation (1), key (64)
// out_ch    out   valid/ready    outcome (3), slot (7), position (7)
//
// a search runs the list walk, which reads one key/link memory entry per cycle
// reset (rst, synchronous) empties the list at once; table memories are not cleared
// one item at a time; the result sits in an output register, so a stalled
// output holds only the finish of the next item, not its acceptance
`default_nettype none

module move_to_front_list_search (
  input  wire        clk,
  input  wire        rst,
  mtf_in_if.sink     in_ch,
  mtf_out_if.source  out_ch
);

  mtf_pkg::cmd_t    cmd;
  mtf_pkg::status_t status;

  // sequencer: accept, append or walk, relink, hand off result
  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // key and link tables, head/tail/count, walk pointers, result registers
  mtf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .out_outcome  (out_ch.outcome),
    .out_slot     (out_ch.slot),
    .out_position (out_ch.position)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mtf_datapath.sv =====
`default_nettype none

module mtf_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  mtf_pkg::cmd_t                 cmd,
  output mtf_pkg::status_t                    status,
  input  wire                                 in_operation,
  input  wire  [mtf_pkg::IN_KEY_W-1:0]        in_key,
  output logic [mtf_pkg::OUTCOME_W-1:0]       out_outcome,
  output logic [mtf_pkg::FIELD_W-1:0]         out_slot,
  output logic [mtf_pkg::FIELD_W-1:0]         out_position
);

  mtf_pkg::key_t  key_mem  [mtf_pkg::ENTRIES];
  mtf_pkg::slot_t link_mem [mtf_pkg::ENTRIES];

  mtf_pkg::key_t   key_q;
  logic            op_q;
  mtf_pkg::slot_t  head;
  mtf_pkg::slot_t  tail;
  mtf_pkg::count_t count;
  mtf_pkg::slot_t  cur;
  mtf_pkg::slot_t  prev;
  mtf_pkg::slot_t  pos;
  mtf_pkg::key_t   key_rd;
  mtf_pkg::slot_t  link_rd;

  logic [mtf_pkg::OUTCOME_W-1:0] res_outcome;
  logic [mtf_pkg::FIELD_W-1:0]   res_slot;
  logic [mtf_pkg::FIELD_W-1:0]   res_pos;

  mtf_pkg::slot_t rd_addr;
  logic           rd_en;
  mtf_pkg::slot_t link_waddr;
  mtf_pkg::slot_t link_wdata;
  logic           link_we;
  mtf_pkg::slot_t new_slot;
  mtf_pkg::count_t pos_plus;

  assign new_slot = count[mtf_pkg::SLOT_BITS-1:0];
  assign pos_plus = mtf_pkg::count_t'(pos) + mtf_pkg::count_t'(1);

  assign rd_en   = cmd.start | cmd.step;
  assign rd_addr = cmd.start ? head : link_rd;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = tail;
    link_wdata = new_slot;
    if (cmd.do_append && count != '0) begin
      link_we = 1'b1;
    end else if (cmd.relink) begin
      link_we    = 1'b1;
      link_waddr = prev;
      link_wdata = link_rd;
    end else if (cmd.front) begin
      link_we    = 1'b1;
      link_waddr = cur;
      link_wdata = head;
    end
  end

  // table memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.do_append) begin
      key_mem[new_slot] <= key_q;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      key_rd  <= key_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.do_append) begin
        if (count == '0) begin
          head <= new_slot;
        end
        tail  <= new_slot;
        count <= count + mtf_pkg::count_t'(1);
      end
      if (cmd.relink && cur == tail) begin
        tail <= prev;
      end
      if (cmd.front) begin
        head <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_operation;
      key_q <= in_key[mtf_pkg::KEY_BITS-1:0];
    end
    if (cmd.start) begin
      cur <= head;
      pos <= '0;
    end else if (cmd.step) begin
      prev <= cur;
      cur  <= link_rd;
      pos  <= pos + mtf_pkg::slot_t'(1);
    end
    if (cmd.set_res) begin
      res_outcome <= cmd.res_code;
      if (cmd.res_code == mtf_pkg::OUT_APPENDED) begin
        res_slot <= mtf_pkg::to_field(new_slot);
      end else if (cmd.res_code == mtf_pkg::OUT_MOVED ||
                   cmd.res_code == mtf_pkg::OUT_AT_FRONT) begin
        res_slot <= mtf_pkg::to_field(cur);
      end else begin
        res_slot <= '0;
      end
      res_pos <= (cmd.res_code == mtf_pkg::OUT_MOVED) ? mtf_pkg::to_field(pos) : '0;
    end
    if (cmd.out_load) begin
      out_outcome  <= res_outcome;
      out_slot     <= res_slot;
      out_position <= res_pos;
    end
  end

  assign status.op         = op_q;
  assign status.count_zero = (count == '0);
  assign status.full       = (count == mtf_pkg::count_t'(mtf_pkg::ENTRIES));
  assign status.key_match  = (key_rd == key_q);
  assign status.pos_zero   = (pos == '0);
  assign status.last       = (pos_plus == count);

endmodule

`default_nettype wire

// ===== rtl/core/mtf_ctrl.sv =====
`default_nettype none

module mtf_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  wire  mtf_pkg::status_t status,
  output mtf_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_RELINK = 3'd4;
  localparam logic [2:0] S_FRONT  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        if (status.op == mtf_pkg::OP_SEARCH) begin
          state_next = S_START;
        end else begin
          cmd.set_res = 1'b1;
          if (status.full) begin
            cmd.res_code = mtf_pkg::OUT_FULL;
          end else begin
            cmd.do_append = 1'b1;
            cmd.res_code  = mtf_pkg::OUT_APPENDED;
          end
          state_next = S_FINISH;
        end
      end
      S_START: begin
        if (status.count_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = mtf_pkg::OUT_MISS;
          state_next   = S_FINISH;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (status.key_match) begin
          if (status.pos_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = mtf_pkg::OUT_AT_FRONT;
            state_next   = S_FINISH;
          end else begin
            state_next = S_RELINK;
          end
        end else if (status.last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = mtf_pkg::OUT_MISS;
          state_next   = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_RELINK: begin
        cmd.relink = 1'b1;
        state_next = S_FRONT;
      end
      S_FRONT: begin
        cmd.front    = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = mtf_pkg::OUT_MOVED;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_move_to_front_list_search.sv =====
`timescale 1ns / 1ps

module tb_move_to_front_list_search;

  // each side holds off in about this many cycles of a hundred
  localparam int IDLE_PCT = 14;
  // longest walk of a search that misses on a full table, plus margin
  localparam int WALK_MAX = mtf_pkg::ENTRIES + 6;
  // cycles with no item moving on either side before the run is given up
  localparam int STALL_LIMIT = 20 * WALK_MAX;
  localparam int RANDOM_ITEMS = 980;
  // random items inside this window run with both sides always willing
  localparam int STEADY_FROM = 400;
  localparam int STEADY_TO = 600;
  localparam int DRAIN_AT = 700;
  localparam int REPORT_MAX = 10;

  typedef logic [mtf_pkg::FIELD_W-1:0] field_t;
  typedef logic [mtf_pkg::IN_KEY_W-1:0] in_key_t;

  typedef struct packed {
    logic [mtf_pkg::OUTCOME_W-1:0] outcome;
    field_t                        slot;
    field_t                        position;
  } mtf_result_t;

  // tracks the list order, predicts each result, and checks the output items
  class mtf_list_tracker;
    mtf_pkg::key_t  keys[mtf_pkg::ENTRIES];
    mtf_pkg::slot_t next_slot[mtf_pkg::ENTRIES];
    mtf_pkg::slot_t head;
    mtf_pkg::slot_t tail;
    int             used;
    int             mismatches;
    mtf_result_t    pending_results[$];

    function new();
      head = '0;
      tail = '0;
      used = 0;
      mismatches = 0;
    endfunction

    // predict the result of one accepted input item
    function void note_item(logic op, in_key_t raw_key);
      mtf_pkg::key_t  k;
      mtf_result_t    r;
      mtf_pkg::slot_t cur;
      mtf_pkg::slot_t prev;
      int             pos;
      bit             hit;
      k = mtf_pkg::key_t'(raw_key);
      r = '0;
      if (op == mtf_pkg::OP_APPEND) begin
        if (used >= mtf_pkg::ENTRIES) begin
          r.outcome = mtf_pkg::OUT_FULL;
        end else begin
          keys[used] = k;
          // first entry becomes the head, later ones hang off the tail
          if (used != 0) next_slot[tail] = mtf_pkg::slot_t'(used);
          else head = mtf_pkg::slot_t'(used);
          tail = mtf_pkg::slot_t'(used);
          r.outcome = mtf_pkg::OUT_APPENDED;
          r.slot = field_t'(used);
          used++;
        end
      end else begin
        r.outcome = mtf_pkg::OUT_MISS;
        cur = head;
        prev = '0;
        pos = 0;
        hit = 1'b0;
        while (!hit && pos < used) begin
          if (keys[cur] == k) begin
            hit = 1'b1;
          end else begin
            prev = cur;
            cur = next_slot[cur];
            pos++;
          end
        end
        if (hit) begin
          r.slot = field_t'(cur);
          if (pos == 0) begin
            r.outcome = mtf_pkg::OUT_AT_FRONT;
          end else begin
            // unlink, then put in front of the old head
            next_slot[prev] = next_slot[cur];
            if (cur == tail) tail = prev;
            next_slot[cur] = head;
            head = cur;
            r.outcome = mtf_pkg::OUT_MOVED;
            r.position = field_t'(pos);
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void report(string what, mtf_result_t want, mtf_result_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s: expected %0d/%0d/%0d got %0d/%0d/%0d (outcome/slot/position)",
                 $realtime, what, want.outcome, want.slot, want.position,
                 got.outcome, got.slot, got.position);
    endfunction

    // compare one output item against the oldest prediction
    function void check_result(logic [mtf_pkg::OUTCOME_W-1:0] outcome, field_t slot,
                               field_t position);
      mtf_result_t got;
      mtf_result_t want;
      got.outcome = outcome;
      got.slot = slot;
      got.position = position;
      if (pending_results.size() == 0) begin
        report("result with nothing expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.outcome !== want.outcome || got.slot !== want.slot ||
            got.position !== want.position)
          report("result mismatch", want, got);
      end
    endfunction

    function int waiting();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   stall_cycles = 0;

  mtf_list_tracker tracker;

  mtf_in_if  in_ch ();
  mtf_out_if out_ch ();

  move_to_front_list_search i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // output side stalls at random except in the steady window
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // both channels are sampled at the rising edge, where the handshake counts
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      tracker.note_item(in_ch.operation, in_ch.key);
    if (!rst && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.outcome, out_ch.slot, out_ch.position);
  end

  // give up when neither side has moved an item for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one item, with random hold-off first, and wait until it is taken
  task automatic send_item(input logic op, input in_key_t k);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the input side until every predicted result has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.waiting() != 0) @(negedge clk);
  endtask

  function automatic in_key_t random_key();
    return {$urandom, $urandom};
  endfunction

  // a key already in the table, or a random one while the table is empty
  function automatic in_key_t stored_key();
    if (tracker.used == 0) return random_key();
    return in_key_t'(tracker.keys[$urandom_range(0, tracker.used - 1)]);
  endfunction

  initial begin
    int      n;
    int      roll;
    in_key_t k;
    tracker = new();
    rst = 1'b1;
    steady = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = mtf_pkg::OP_APPEND;
    in_ch.key = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed part
    // search on an empty list misses
    send_item(mtf_pkg::OP_SEARCH, '0);
    // key extremes and a word of eight characters
    send_item(mtf_pkg::OP_APPEND, '0);
    send_item(mtf_pkg::OP_APPEND, '1);
    send_item(mtf_pkg::OP_APPEND, 64'h4142_4344_4546_4748);
    // hit at the front stays put
    send_item(mtf_pkg::OP_SEARCH, '0);
    // hit one down moves to the front
    send_item(mtf_pkg::OP_SEARCH, '1);
    // hit at the tail, predecessor becomes the tail
    send_item(mtf_pkg::OP_SEARCH, 64'h4142_4344_4546_4748);
    // append must link after the new tail
    send_item(mtf_pkg::OP_APPEND, 64'h0000_0000_0000_0041);
    send_item(mtf_pkg::OP_SEARCH, 64'h0000_0000_0000_0041);
    // duplicate key, the one nearer the front wins
    send_item(mtf_pkg::OP_APPEND, '1);
    send_item(mtf_pkg::OP_SEARCH, '1);
    send_item(mtf_pkg::OP_SEARCH, '1);
    // misses on a non-empty list, single high bit and near neighbours
    send_item(mtf_pkg::OP_SEARCH, 64'h8000_0000_0000_0000);
    send_item(mtf_pkg::OP_SEARCH, 64'h0000_0000_0000_0001);
    send_item(mtf_pkg::OP_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(mtf_pkg::OP_APPEND, 64'h5555_5555_5555_5555);
    send_item(mtf_pkg::OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(mtf_pkg::OP_SEARCH, 64'h5555_5555_5555_5555);
    send_item(mtf_pkg::OP_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(mtf_pkg::OP_SEARCH, 64'h4142_4344_4546_4748);
    wait_for_results();

    // random part: the table fills on the way, then appends report full
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      if (n == DRAIN_AT) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < ((tracker.used < mtf_pkg::ENTRIES) ? 25 : 5)) begin
        // mostly fresh keys, some duplicates of stored ones
        k = ($urandom_range(0, 9) == 0) ? stored_key() : random_key();
        send_item(mtf_pkg::OP_APPEND, k);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          k = stored_key();
        end else if (roll < 88) begin
          // near miss, one bit away from a stored key
          k = stored_key() ^ (in_key_t'(1) << $urandom_range(0, mtf_pkg::IN_KEY_W - 1));
        end else begin
          k = random_key();
        end
        send_item(mtf_pkg::OP_SEARCH, k);
      end
    end
    steady = 1'b0;

    wait_for_results();
    // let any late or spurious output item show up
    repeat (WALK_MAX) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
